### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the lexer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define EXL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define EXL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/exl_pkg.sv
// ----------------------------------------------------------------------------
// exl_pkg
// Types, constants and character classing shared by the lexer modules.
// ----------------------------------------------------------------------------
package exl_pkg;

    localparam int CHAR_BITS      = 8;
    localparam int KIND_BITS      = 4;
    localparam int VALUE_BITS_DEF = 31;
    localparam int QUEUE_DEPTH    = 4;

    // Character codes
    localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_BITS-1:0] CH_FF     = 8'h0C;
    localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_BITS-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CHAR_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_IDENT   = 3'd4,
        MODE_NUMBER  = 3'd5
    } exl_mode_t;

    typedef enum logic [KIND_BITS-1:0] {
        K_NEWLINE = 4'd0,
        K_SEMI    = 4'd1,
        K_DIVIDE  = 4'd2,
        K_STRING  = 4'd3,
        K_IDENT   = 4'd4,
        K_ASSIGN  = 4'd5,
        K_NUMBER  = 4'd6,
        K_PLUS    = 4'd7,
        K_MINUS   = 4'd8,
        K_TIMES   = 4'd9,
        K_LPAREN  = 4'd10,
        K_RPAREN  = 4'd11,
        K_EOF     = 4'd12,
        K_UNKNOWN = 4'd13
    } exl_kind_t;

    // One result beat, without the number value (its width is a parameter)
    typedef struct packed {
        exl_kind_t            kind;
        logic [CHAR_BITS-1:0] text_char;
        logic                 char_valid;
        logic                 token_end;
        logic                 number_overflow;
        logic                 last_result;
    } exl_tok_t;

    // What a byte does when scanned from idle
    typedef struct packed {
        logic      emit;
        exl_kind_t kind;
        logic      char_valid;
        exl_mode_t mode;
        logic      num_start;
    } exl_class_t;

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
        return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_ident_char(input logic [CHAR_BITS-1:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic exl_tok_t mk_tok(input exl_kind_t kind,
                                        input logic [CHAR_BITS-1:0] ch,
                                        input logic cv,
                                        input logic ovf);
        exl_tok_t t;
        t.kind            = kind;
        t.text_char       = cv ? ch : '0;
        t.char_valid      = cv;
        t.token_end       = !cv;
        t.number_overflow = ovf;
        t.last_result     = 1'b0;
        return t;
    endfunction

    // Classify a byte seen in idle mode
    function automatic exl_class_t idle_class(input logic [CHAR_BITS-1:0] c);
        exl_class_t r;
        r.emit       = 1'b1;
        r.kind       = K_UNKNOWN;
        r.char_valid = 1'b0;
        r.mode       = MODE_IDLE;
        r.num_start  = 1'b0;
        if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)
            || (c == CH_CR)) begin
            r.emit = 1'b0;
        end else if (c == CH_NL) begin
            r.kind = K_NEWLINE;
        end else if (c == CH_SEMI) begin
            r.kind = K_SEMI;
        end else if (c == CH_SLASH) begin
            r.emit = 1'b0;
            r.mode = MODE_SLASH;
        end else if (c == CH_QUOTE) begin
            r.emit = 1'b0;
            r.mode = MODE_STRING;
        end else if (is_alpha(c) || (c == CH_UNDER)) begin
            r.kind       = K_IDENT;
            r.char_valid = 1'b1;
            r.mode       = MODE_IDENT;
        end else if (c == CH_EQUAL) begin
            r.kind = K_ASSIGN;
        end else if (is_digit(c)) begin
            r.emit      = 1'b0;
            r.mode      = MODE_NUMBER;
            r.num_start = 1'b1;
        end else if (c == CH_PLUS) begin
            r.kind = K_PLUS;
        end else if (c == CH_MINUS) begin
            r.kind = K_MINUS;
        end else if (c == CH_STAR) begin
            r.kind = K_TIMES;
        end else if (c == CH_LPAREN) begin
            r.kind = K_LPAREN;
        end else if (c == CH_RPAREN) begin
            r.kind = K_RPAREN;
        end
        return r;
    endfunction

endpackage

### src/expression_lexer_unit.sv
// ----------------------------------------------------------------------------
// expression_lexer_unit
// Byte-serial tokenizer for a small expression language.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one source byte, or an end mark
//   on end_of_input, per beat. Output channel (out_valid/out_stall) gives
//   one result per beat; last_result marks the final result of a byte.
//   Identifiers and strings stream one character per beat, then an end beat.
//   A byte gives zero, one or two results.
// Path: a taken byte waits in the input register, then is decoded into
//   the result queue, whose head drives the result ports.
// Throughput: one byte per cycle while each byte gives at most one result
//   and the queue has room; a byte with two results uses two output beats.
//   The output side, one beat a cycle unless stalled, sets the sustained rate.
// Stall: a four-entry result queue parts the channels; in_stall rises when
//   the queue cannot take two more beats and a byte is waiting to decode.
// Reset: the scan returns to idle, the number accumulator clears and the
//   queue empties; nothing is emitted until new bytes arrive.
// ----------------------------------------------------------------------------
module expression_lexer_unit #(
    parameter int VALUE_BITS = exl_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [exl_pkg::CHAR_BITS-1:0]   in_char,
    input  logic                            end_of_input,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [exl_pkg::KIND_BITS-1:0]   token_kind,
    output logic [exl_pkg::CHAR_BITS-1:0]   text_char,
    output logic                            char_valid,
    output logic                            token_end,
    output logic [VALUE_BITS-1:0]           number_value,
    output logic                            number_overflow,
    output logic                            last_result
);
    import exl_pkg::*;

    logic                  in_valid_reg;
    logic [CHAR_BITS-1:0]  in_char_reg;
    logic                  eoi_reg;
    logic                  room;
    logic                  step;
    logic [1:0]            res_count;
    logic [1:0]            push_count;
    exl_tok_t              res0;
    exl_tok_t              res1;
    logic [VALUE_BITS-1:0] res0_value;
    exl_tok_t              head;

    assign step       = in_valid_reg && room;
    assign in_stall   = in_valid_reg && !room;
    assign push_count = step ? res_count : 2'd0;

    // Input register: hold while the queue is short of room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            in_char_reg <= in_char;
            eoi_reg     <= end_of_input;
        end
    end

    exl_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .in_char      (in_char_reg),
        .end_of_input (eoi_reg),
        .res_count    (res_count),
        .res0         (res0),
        .res1         (res1),
        .res0_value   (res0_value)
    );

    exl_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push0       (res0),
        .push1       (res1),
        .push0_value (res0_value),
        .pop         (!out_stall),
        .room        (room),
        .head_valid  (out_valid),
        .head        (head),
        .head_value  (number_value)
    );

    // Drive result fields from the queue head
    assign token_kind      = head.kind;
    assign text_char       = head.text_char;
    assign char_valid      = head.char_valid;
    assign token_end       = head.token_end;
    assign number_overflow = head.number_overflow;
    assign last_result     = head.last_result;

endmodule

### src/exl_core.sv
// ----------------------------------------------------------------------------
// exl_core
// Scan state and combinational token decode: one byte in, up to two beats out.
// ----------------------------------------------------------------------------
module exl_core #(
    parameter int VALUE_BITS = exl_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [exl_pkg::CHAR_BITS-1:0]  in_char,
    input  logic                           end_of_input,
    output logic [1:0]                     res_count,
    output exl_pkg::exl_tok_t              res0,
    output exl_pkg::exl_tok_t              res1,
    output logic [VALUE_BITS-1:0]          res0_value
);
    import exl_pkg::*;

    localparam int PROD_BITS = VALUE_BITS + 4;

    exl_mode_t             mode_reg, mode_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  ovf_reg, ovf_next;

    exl_class_t            ic;
    logic [3:0]            digit;
    logic [PROD_BITS-1:0]  prod;
    logic                  sat;
    logic [VALUE_BITS-1:0] acc_step;
    logic [VALUE_BITS-1:0] digit_value;

    logic                  first;
    exl_tok_t              first_tok;
    logic [VALUE_BITS-1:0] first_value;
    logic                  second_ok;
    exl_tok_t              second_tok;
    logic                  idle_used;

    // Classify the byte and form the saturating decimal step
    always_comb
    begin
        ic          = idle_class(in_char);
        digit       = in_char[3:0] - CH_ZERO[3:0];
        digit_value = VALUE_BITS'(digit);
        prod        = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + PROD_BITS'(digit);
        sat         = |prod[PROD_BITS-1:VALUE_BITS];
        acc_step    = sat ? '1 : prod[VALUE_BITS-1:0];
    end

    // Next scan state
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        ovf_next  = ovf_reg;
        idle_used = 1'b0;
        if (end_of_input) begin
            mode_next = MODE_IDLE;
            acc_next  = '0;
            ovf_next  = 1'b0;
        end else begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (in_char == CH_SLASH) begin
                        mode_next = MODE_COMMENT;
                    end else begin
                        idle_used = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (in_char == CH_NL) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    if (in_char == CH_QUOTE) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_IDENT:
                begin
                    if (!is_ident_char(in_char)) begin
                        idle_used = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(in_char)) begin
                        acc_next = acc_step;
                        ovf_next = ovf_reg | sat;
                    end else begin
                        acc_next  = '0;
                        ovf_next  = 1'b0;
                        idle_used = 1'b1;
                    end
                end
                default:
                begin
                    idle_used = 1'b1;
                end
            endcase
            if (idle_used) begin
                mode_next = ic.mode;
                if (ic.num_start) begin
                    acc_next = digit_value;
                    ovf_next = 1'b0;
                end
            end
        end
    end

    // Result beats
    always_comb
    begin
        first       = 1'b0;
        first_tok   = mk_tok(K_EOF, in_char, 1'b0, 1'b0);
        first_value = '0;
        second_tok  = mk_tok(ic.kind, in_char, ic.char_valid, 1'b0);
        second_ok   = idle_used & ic.emit;
        if (end_of_input) begin
            second_tok = mk_tok(K_EOF, in_char, 1'b0, 1'b0);
            second_ok  = 1'b1;
            case (mode_reg)
                MODE_SLASH:
                begin
                    first     = 1'b1;
                    first_tok = mk_tok(K_DIVIDE, in_char, 1'b0, 1'b0);
                end
                MODE_STRING:
                begin
                    first     = 1'b1;
                    first_tok = mk_tok(K_STRING, in_char, 1'b0, 1'b0);
                end
                MODE_IDENT:
                begin
                    first     = 1'b1;
                    first_tok = mk_tok(K_IDENT, in_char, 1'b0, 1'b0);
                end
                MODE_NUMBER:
                begin
                    first       = 1'b1;
                    first_tok   = mk_tok(K_NUMBER, in_char, 1'b0, ovf_reg);
                    first_value = acc_reg;
                end
                default:
                begin
                    first = 1'b0;
                end
            endcase
        end else begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    first     = (in_char != CH_SLASH);
                    first_tok = mk_tok(K_DIVIDE, in_char, 1'b0, 1'b0);
                end
                MODE_STRING:
                begin
                    first     = 1'b1;
                    first_tok = mk_tok(K_STRING, in_char, (in_char != CH_QUOTE), 1'b0);
                end
                MODE_IDENT:
                begin
                    first     = 1'b1;
                    first_tok = mk_tok(K_IDENT, in_char, is_ident_char(in_char), 1'b0);
                end
                MODE_NUMBER:
                begin
                    first       = !is_digit(in_char);
                    first_tok   = mk_tok(K_NUMBER, in_char, 1'b0, ovf_reg);
                    first_value = acc_reg;
                end
                default:
                begin
                    first = 1'b0;
                end
            endcase
        end

        res_count             = {1'b0, first} + {1'b0, second_ok};
        res0                  = first ? first_tok : second_tok;
        res0.last_result      = !(first && second_ok);
        res0_value            = first ? first_value : '0;
        res1                  = second_tok;
        res1.last_result      = 1'b1;
    end

    // Advance scan state on each byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (step) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

### src/exl_queue.sv
// ----------------------------------------------------------------------------
// exl_queue
// Small result queue: up to two beats in a cycle, one out a cycle on pop.
// ----------------------------------------------------------------------------
module exl_queue #(
    parameter int VALUE_BITS = exl_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            push_count,
    input  exl_pkg::exl_tok_t     push0,
    input  exl_pkg::exl_tok_t     push1,
    input  logic [VALUE_BITS-1:0] push0_value,
    input  logic                  pop,
    output logic                  room,
    output logic                  head_valid,
    output exl_pkg::exl_tok_t     head,
    output logic [VALUE_BITS-1:0] head_value
);
    import exl_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = PTR_BITS + 1;

    exl_tok_t              tok_mem_reg [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0] val_mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [PTR_BITS-1:0]   wr_ptr_plus1;
    logic                  do_pop;

    assign head_valid   = (count_reg != '0);
    assign head         = tok_mem_reg[rd_ptr_reg];
    assign head_value   = val_mem_reg[rd_ptr_reg];
    assign room         = (count_reg <= CNT_BITS'(QUEUE_DEPTH - 2));
    assign do_pop       = pop && head_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(do_pop);
        count_next  = count_reg + CNT_BITS'(push_count) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write entries; only the first beat of a byte can carry a number
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            tok_mem_reg[wr_ptr_reg] <= push0;
            val_mem_reg[wr_ptr_reg] <= push0_value;
        end
        if (push_count == 2'd2) begin
            tok_mem_reg[wr_ptr_plus1] <= push1;
            val_mem_reg[wr_ptr_plus1] <= '0;
        end
    end

endmodule

### src/exl_checker.sv
// ----------------------------------------------------------------------------
// exl_checker
// Port-level checks on the lexer result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module exl_checker #(
    parameter int VALUE_BITS = exl_pkg::VALUE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [exl_pkg::KIND_BITS-1:0] token_kind,
    input logic                          char_valid,
    input logic                          token_end,
    input logic [VALUE_BITS-1:0]         number_value,
    input logic                          number_overflow,
    input logic                          last_result
);
    import exl_pkg::*;

    // Hold a stalled result
    `EXL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(token_kind) && $stable(number_value), "stalled result changed")

    // A streamed character belongs to a string or identifier and never ends it
    `EXL_ASSERT_SAME(a_char_kind, clk, rst_n, out_valid && char_valid, !token_end && (token_kind == K_STRING || token_kind == K_IDENT), "bad streamed character")

    // Only number tokens carry a value or an overflow flag
    `EXL_ASSERT_SAME(a_value_zero, clk, rst_n, out_valid && token_kind != K_NUMBER, number_value == '0 && !number_overflow, "value on non-number")

    // A saturated number holds the top value
    `EXL_ASSERT_SAME(a_sat_value, clk, rst_n, out_valid && number_overflow, number_value == '1, "bad saturated value")

    // An eof beat is always the last beat of its byte
    `EXL_ASSERT_SAME(a_eof_last, clk, rst_n, out_valid && token_kind == K_EOF, last_result, "eof beat not last")

endmodule

bind expression_lexer_unit exl_checker #(
    .VALUE_BITS (VALUE_BITS)
) u_exl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .token_kind      (token_kind),
    .char_valid      (char_valid),
    .token_end       (token_end),
    .number_value    (number_value),
    .number_overflow (number_overflow),
    .last_result     (last_result)
);

### dv/tb_expression_lexer_unit.sv
// ----------------------------------------------------------------------------
// tb_expression_lexer_unit
// Self-checking testbench for the byte-serial expression tokenizer.
// ----------------------------------------------------------------------------
// A short directed sequence walks every token kind but newline and the corner
// cases of the scanner. Random source text follows, built from mostly
// well-formed fragments (names, numbers, strings, comments, operators) mixed
// with raw noise bytes and end marks. A scoreboard tracks the scanner state
// for every accepted input beat and checks each result beat in order. Both
// channels idle and stall at random, and the receiver holds off for a long
// stretch once so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_expression_lexer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import exl_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;
    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER = 150;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    localparam logic [CHAR_BITS-1:0] OP_BYTES [9] = '{
        CH_NL, CH_SEMI, CH_EQUAL, CH_PLUS, CH_MINUS,
        CH_STAR, CH_LPAREN, CH_RPAREN, CH_SLASH
    };
    localparam logic [CHAR_BITS-1:0] BLANK_BYTES [5] = '{
        CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR
    };

    // One result beat as seen on the output ports
    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [CHAR_BITS-1:0]  text_char;
        logic                  char_valid;
        logic                  token_end;
        logic [VALUE_BITS-1:0] number_value;
        logic                  number_overflow;
        logic                  last_result;
    } lex_token_t;

    // ------------------------------------------------------------------------
    // Token scoreboard: tracks the scan state and holds the expected beats
    // ------------------------------------------------------------------------
    class token_scoreboard;
        exl_mode_t             lex_state;
        logic [VALUE_BITS-1:0] value_sum;
        logic                  value_clipped;
        lex_token_t            pending_tokens[$];
        lex_token_t            step_tokens[$];
        int                    mismatches;

        function new();
            clear_scan();
            mismatches = 0;
        endfunction

        function void clear_scan();
            lex_state     = MODE_IDLE;
            value_sum     = '0;
            value_clipped = 1'b0;
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        function bit is_letter(input logic [CHAR_BITS-1:0] c);
            return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
        endfunction

        function bit is_decimal(input logic [CHAR_BITS-1:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void push_token(input exl_kind_t kind, input logic [CHAR_BITS-1:0] ch,
                                 input logic cv, input logic [VALUE_BITS-1:0] val,
                                 input logic ovf);
            lex_token_t t;
            t.kind            = kind;
            t.text_char       = cv ? ch : '0;
            t.char_valid      = cv;
            t.token_end       = !cv;
            t.number_value    = val;
            t.number_overflow = ovf;
            t.last_result     = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function void push_marker(input exl_kind_t kind);
            push_token(kind, '0, 1'b0, '0, 1'b0);
        endfunction

        // Fold one digit into the value, clipping at the top of the range
        function void add_digit(input logic [CHAR_BITS-1:0] c);
            longint unsigned d;
            d = c - CH_ZERO;
            if (value_sum > (VALUE_MAX - d) / 10) begin
                value_sum     = VALUE_MAX[VALUE_BITS-1:0];
                value_clipped = 1'b1;
            end else begin
                value_sum = VALUE_BITS'(value_sum * 10 + d);
            end
        endfunction

        function void close_number();
            push_token(K_NUMBER, '0, 1'b0, value_sum, value_clipped);
            value_sum     = '0;
            value_clipped = 1'b0;
        endfunction

        // Handle a byte with no token open
        function void scan_idle(input logic [CHAR_BITS-1:0] c);
            lex_state = MODE_IDLE;
            case (c)
                CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
                CH_NL:     push_marker(K_NEWLINE);
                CH_SEMI:   push_marker(K_SEMI);
                CH_SLASH:  lex_state = MODE_SLASH;
                CH_QUOTE:  lex_state = MODE_STRING;
                CH_EQUAL:  push_marker(K_ASSIGN);
                CH_PLUS:   push_marker(K_PLUS);
                CH_MINUS:  push_marker(K_MINUS);
                CH_STAR:   push_marker(K_TIMES);
                CH_LPAREN: push_marker(K_LPAREN);
                CH_RPAREN: push_marker(K_RPAREN);
                default: begin
                    if (is_letter(c) || c == CH_UNDER) begin
                        push_token(K_IDENT, c, 1'b1, '0, 1'b0);
                        lex_state = MODE_IDENT;
                    end else if (is_decimal(c)) begin
                        value_sum     = '0;
                        value_clipped = 1'b0;
                        add_digit(c);
                        lex_state = MODE_NUMBER;
                    end else begin
                        push_marker(K_UNKNOWN);
                    end
                end
            endcase
        endfunction

        // Note one accepted input beat and queue the results it causes
        function void take_byte(input logic [CHAR_BITS-1:0] c, input logic eoi);
            lex_token_t t;
            step_tokens.delete();
            if (eoi) begin
                case (lex_state)
                    MODE_SLASH:  push_marker(K_DIVIDE);
                    MODE_STRING: push_marker(K_STRING);
                    MODE_IDENT:  push_marker(K_IDENT);
                    MODE_NUMBER: close_number();
                    default: ;
                endcase
                push_marker(K_EOF);
                clear_scan();
            end else begin
                case (lex_state)
                    MODE_SLASH: begin
                        if (c == CH_SLASH) begin
                            lex_state = MODE_COMMENT;
                        end else begin
                            push_marker(K_DIVIDE);
                            scan_idle(c);
                        end
                    end
                    MODE_COMMENT: begin
                        if (c == CH_NL)
                            lex_state = MODE_IDLE;
                    end
                    MODE_STRING: begin
                        if (c == CH_QUOTE) begin
                            push_marker(K_STRING);
                            lex_state = MODE_IDLE;
                        end else begin
                            push_token(K_STRING, c, 1'b1, '0, 1'b0);
                        end
                    end
                    MODE_IDENT: begin
                        if (is_letter(c) || is_decimal(c) || c == CH_UNDER) begin
                            push_token(K_IDENT, c, 1'b1, '0, 1'b0);
                        end else begin
                            push_marker(K_IDENT);
                            scan_idle(c);
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_decimal(c)) begin
                            add_digit(c);
                        end else begin
                            close_number();
                            scan_idle(c);
                        end
                    end
                    default: scan_idle(c);
                endcase
            end
            // Mark the final beat of this byte
            if (step_tokens.size() > 0) begin
                t = step_tokens.pop_back();
                t.last_result = 1'b1;
                step_tokens.push_back(t);
            end
            foreach (step_tokens[i])
                pending_tokens.push_back(step_tokens[i]);
        endfunction

        function string describe(input lex_token_t t);
            return $sformatf("kind %0d char %02h cv %0b end %0b value %0d ovf %0b last %0b",
                             t.kind, t.text_char, t.char_valid, t.token_end,
                             t.number_value, t.number_overflow, t.last_result);
        endfunction

        // Compare one accepted result beat with the oldest expectation
        function void match_token(input lex_token_t got);
            lex_token_t want;
            if (pending_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result: %s", $realtime, describe(got));
                return;
            end
            want = pending_tokens.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result mismatch", $realtime);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [CHAR_BITS-1:0]  in_char = '0;
    logic                  end_of_input = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [KIND_BITS-1:0]  token_kind;
    logic [CHAR_BITS-1:0]  text_char;
    logic                  char_valid;
    logic                  token_end;
    logic [VALUE_BITS-1:0] number_value;
    logic                  number_overflow;
    logic                  last_result;

    token_scoreboard sb = new();
    int  accepted_items = 0;
    int  random_items = 0;
    int  burst_left = 0;
    int  cycle_count = 0;

    expression_lexer_unit #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_char         (in_char),
        .end_of_input    (end_of_input),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .text_char       (text_char),
        .char_valid      (char_valid),
        .token_end       (token_end),
        .number_value    (number_value),
        .number_overflow (number_overflow),
        .last_result     (last_result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watch both channels: note input beats first, then check result beats
    always @(posedge clk) begin
        lex_token_t got;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.take_byte(in_char, end_of_input);
                accepted_items++;
            end
            if (out_valid && !out_stall) begin
                got.kind            = token_kind;
                got.text_char       = text_char;
                got.char_valid      = char_valid;
                got.token_end       = token_end;
                got.number_value    = number_value;
                got.number_overflow = number_overflow;
                got.last_result     = last_result;
                sb.match_token(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Pick the idle gap before the next beat; bursts run with no gaps
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            burst_left = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one beat and hold it until the block takes it
    task automatic send_item(input logic [CHAR_BITS-1:0] c, input logic eoi,
                             input bit counts);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_char      <= c;
        end_of_input <= eoi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (counts)
            random_items++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0, 1'b1);
    endtask

    function automatic logic [CHAR_BITS-1:0] pick_word_char(input bit lead);
        case ($urandom_range(lead ? 1 : 0, 6))
            0:       return CHAR_BITS'(CH_ZERO + $urandom_range(0, 9));
            1, 2:    return CHAR_BITS'(CH_LO_A + $urandom_range(0, 25));
            3, 4:    return CHAR_BITS'(CH_UP_A + $urandom_range(0, 25));
            5:       return CH_UNDER;
            default: return CHAR_BITS'(CH_LO_A + $urandom_range(0, 25));
        endcase
    endfunction

    // Send one random fragment of source text
    task automatic send_fragment();
        int r;
        int len;
        logic [CHAR_BITS-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            // name: a leading letter or underscore, then word characters
            send_item(pick_word_char(1'b1), 1'b0, 1'b1);
            len = $urandom_range(0, 7);
            repeat (len) send_item(pick_word_char(1'b0), 1'b0, 1'b1);
        end else if (r < 30) begin
            // number: mostly short, some long enough to clip
            case ($urandom_range(0, 19))
                0:       send_text("2147483647");
                1:       send_text("2147483648");
                2, 3:    len = $urandom_range(11, 13);
                4, 5:    len = $urandom_range(9, 10);
                default: len = $urandom_range(1, 4);
            endcase
            if (len > 0)
                repeat (len)
                    send_item(CHAR_BITS'(CH_ZERO + $urandom_range(0, 9)), 1'b0, 1'b1);
        end else if (r < 40) begin
            // string of any bytes, sometimes left open
            send_item(CH_QUOTE, 1'b0, 1'b1);
            len = $urandom_range(0, 8);
            repeat (len) begin
                do c = CHAR_BITS'($urandom_range(0, 255)); while (c == CH_QUOTE);
                send_item(c, 1'b0, 1'b1);
            end
            if ($urandom_range(0, 99) < 85)
                send_item(CH_QUOTE, 1'b0, 1'b1);
        end else if (r < 47) begin
            // comment, sometimes without its closing newline
            send_item(CH_SLASH, 1'b0, 1'b1);
            send_item(CH_SLASH, 1'b0, 1'b1);
            len = $urandom_range(0, 6);
            repeat (len) begin
                do c = CHAR_BITS'($urandom_range(0, 255)); while (c == CH_NL);
                send_item(c, 1'b0, 1'b1);
            end
            if ($urandom_range(0, 99) < 85)
                send_item(CH_NL, 1'b0, 1'b1);
        end else if (r < 73) begin
            send_item(OP_BYTES[$urandom_range(0, 8)], 1'b0, 1'b1);
        end else if (r < 85) begin
            send_item(BLANK_BYTES[$urandom_range(0, 4)], 1'b0, 1'b1);
        end else if (r < 94) begin
            send_item(CHAR_BITS'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else begin
            send_item(CHAR_BITS'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, free runs, and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        bit held_off;
        int r;
        held_off = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_off && accepted_items >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end else if (r < 60) begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else if (r < 90) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(8, 30)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run limit
    // ------------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // End mark while idle, with a byte that must be ignored
        send_item(8'hFF, 1'b1, 1'b0);
        // Extreme bytes fall out as unknown tokens
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        // Newline inside a string, a name closed by an operator, a lone
        // divide closed by a paren, a comment, a number closed by a
        // semicolon, the remaining operators, and a number closed by the end
        send_text("\"\n\"x9+/(//q\n12;-*)= 7");
        send_item(8'hA5, 1'b1, 1'b0);

        // Random source text
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
            send_fragment();
        in_valid <= 1'b0;

        // Let the last input beat reach the scoreboard, then drain
        @(negedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/exl_pkg.sv
src/exl_core.sv
src/exl_queue.sv
src/expression_lexer_unit.sv
src/exl_checker.sv
dv/tb_expression_lexer_unit.sv
